// ----- src/cnsn_pkg.sv -----
// ----------------------------------------------------------------------------
// cnsn_pkg
// Shared types, widths and constants of the crop, nearest-neighbour scale and
// normalise block.
// ----------------------------------------------------------------------------
package cnsn_pkg;

    // Field widths fixed by the interface.
    localparam int PIX_W       = 8;
    localparam int DIM_W       = 11;
    localparam int STRIDE_W    = 12;
    localparam int FRAC_W      = 16;
    localparam int ROW_W       = 12;
    localparam int LOAD_ADDR_W = 21;
    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 16;
    localparam int CHAN_W      = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Width of a computed byte address: row (12 bits) times stride (12 bits) plus column,
    // wide enough to also hold the largest store size.
    localparam int ADDR_CALC_W = 25;

    // Output grid size; the scale division is a shift by its logarithm.
    localparam int OUT_SIZE  = 256;
    localparam int OUT_SHIFT = $clog2(OUT_SIZE);

    // 0.9 in Q0.16.
    localparam logic [FRAC_W-1:0] FRAC_MAX = 16'd58982;

    // Defaults for the top level parameters.
    localparam int OUT_CHANNELS_DEF = 3;
    localparam int STORE_BYTES_DEF  = 2097152;

    // Register reset values.
    localparam logic [DIM_W-1:0]    SRC_WIDTH_RST     = 11'd640;
    localparam logic [DIM_W-1:0]    SRC_HEIGHT_RST    = 11'd480;
    localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST    = 12'd640;
    localparam logic [FRAC_W-1:0]   CROP_TOP_FRAC_RST = 16'd0;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SRC_WIDTH     = 2'd0,
        REG_SRC_HEIGHT    = 2'd1,
        REG_ROW_STRIDE    = 2'd2,
        REG_CROP_TOP_FRAC = 2'd3
    } cfg_index_t;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_REQUEST = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_GEOMETRY = 2'd1,
        STS_RANGE    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_READ,
        S_EMIT
    } state_t;

    typedef struct packed {
        action_t                action;
        logic [LOAD_ADDR_W-1:0] load_address;
        logic [BYTE_W-1:0]      load_byte;
        logic [PIX_W-1:0]       out_x;
        logic [PIX_W-1:0]       out_y;
    } in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value_norm;
        logic [CHAN_W-1:0]  channel;
        logic               last_channel;
        status_t            status;
    } out_t;

    typedef struct packed {
        logic [DIM_W-1:0]    src_width;
        logic [DIM_W-1:0]    src_height;
        logic [STRIDE_W-1:0] row_stride;
        logic [FRAC_W-1:0]   crop_top_frac;
    } geom_t;

    // Stage strobes from the sequencer to the address datapath.
    typedef struct packed {
        logic capture;
        logic mul1;
        logic mul2;
        logic mul3;
    } dp_ctrl_t;

endpackage

// ----- src/cnsn_ram.sv -----
// ----------------------------------------------------------------------------
// cnsn_ram
// Generic simple dual-port RAM: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module cnsn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/cnsn_addr_gen.sv -----
// ----------------------------------------------------------------------------
// cnsn_addr_gen
// Source address datapath: crop offset, nearest-neighbour column and row, and
// the byte address, one multiplication per stage but two in the first.
// ----------------------------------------------------------------------------
module cnsn_addr_gen (
    input  logic                                clk,
    input  cnsn_pkg::dp_ctrl_t                  ctrl,
    input  cnsn_pkg::geom_t                     geom,
    input  logic [cnsn_pkg::PIX_W-1:0]          out_x,
    input  logic [cnsn_pkg::PIX_W-1:0]          out_y,
    output logic [cnsn_pkg::ADDR_CALC_W-1:0]    addr,
    output logic                                geom_bad
);

    localparam int TOP_PROD_W = cnsn_pkg::DIM_W + cnsn_pkg::FRAC_W;
    localparam int PIX_PROD_W = cnsn_pkg::PIX_W + cnsn_pkg::DIM_W;
    localparam int ROW_PROD_W = cnsn_pkg::ROW_W + cnsn_pkg::STRIDE_W;

    logic [cnsn_pkg::PIX_W-1:0]       ox_reg;
    logic [cnsn_pkg::PIX_W-1:0]       oy_reg;
    logic [cnsn_pkg::DIM_W-1:0]       crop_top_reg;
    logic [cnsn_pkg::DIM_W-1:0]       crop_top_next;
    logic [cnsn_pkg::DIM_W-1:0]       sx_reg;
    logic [cnsn_pkg::DIM_W-1:0]       sx_next;
    logic                             geom_bad_reg;
    logic                             geom_bad_next;
    logic [cnsn_pkg::ROW_W-1:0]       row_reg;
    logic [cnsn_pkg::ROW_W-1:0]       row_next;
    logic [cnsn_pkg::ADDR_CALC_W-1:0] addr_reg;
    logic [cnsn_pkg::ADDR_CALC_W-1:0] addr_next;

    logic [cnsn_pkg::FRAC_W-1:0] frac_clamped;
    logic [TOP_PROD_W-1:0]       top_prod;
    logic [cnsn_pkg::DIM_W-1:0]  top_raw;
    logic [cnsn_pkg::DIM_W-1:0]  height_m1;
    logic [PIX_PROD_W-1:0]       sx_prod;
    logic [cnsn_pkg::DIM_W-1:0]  sx_raw;
    logic [cnsn_pkg::DIM_W-1:0]  width_m1;
    logic [cnsn_pkg::DIM_W-1:0]  crop_h_raw;
    logic [cnsn_pkg::DIM_W-1:0]  crop_h;
    logic [cnsn_pkg::DIM_W-1:0]  crop_h_m1;
    logic [PIX_PROD_W-1:0]       sy_prod;
    logic [cnsn_pkg::DIM_W-1:0]  sy_raw;
    logic [cnsn_pkg::DIM_W-1:0]  sy;
    logic [ROW_PROD_W-1:0]       row_prod;

    // First stage: crop offset, source column and geometry check.
    always_comb
    begin
        frac_clamped  = (geom.crop_top_frac > cnsn_pkg::FRAC_MAX) ? cnsn_pkg::FRAC_MAX
                                                                    : geom.crop_top_frac;
        top_prod      = TOP_PROD_W'(geom.src_height) * TOP_PROD_W'(frac_clamped);
        top_raw       = top_prod[cnsn_pkg::FRAC_W +: cnsn_pkg::DIM_W];
        height_m1     = geom.src_height - 1'b1;
        crop_top_next = (top_raw > height_m1) ? height_m1 : top_raw;

        sx_prod  = PIX_PROD_W'(ox_reg) * PIX_PROD_W'(geom.src_width);
        sx_raw   = sx_prod[cnsn_pkg::OUT_SHIFT +: cnsn_pkg::DIM_W];
        width_m1 = geom.src_width - 1'b1;
        sx_next  = (sx_raw > width_m1) ? width_m1 : sx_raw;

        geom_bad_next = (geom.src_width == '0) || (geom.src_height <= 11'd1)
                        || (geom.row_stride == '0);
    end

    // Second stage: source row within the cropped window.
    always_comb
    begin
        crop_h_raw = geom.src_height - crop_top_reg;
        crop_h     = (crop_h_raw == '0) ? 11'd1 : crop_h_raw;
        crop_h_m1  = crop_h - 1'b1;
        sy_prod    = PIX_PROD_W'(oy_reg) * PIX_PROD_W'(crop_h);
        sy_raw     = sy_prod[cnsn_pkg::OUT_SHIFT +: cnsn_pkg::DIM_W];
        sy         = (sy_raw > crop_h_m1) ? crop_h_m1 : sy_raw;
        row_next   = cnsn_pkg::ROW_W'(crop_top_reg) + cnsn_pkg::ROW_W'(sy);
    end

    // Third stage: byte address.
    always_comb
    begin
        row_prod  = ROW_PROD_W'(row_reg) * ROW_PROD_W'(geom.row_stride);
        addr_next = cnsn_pkg::ADDR_CALC_W'(row_prod) + cnsn_pkg::ADDR_CALC_W'(sx_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            ox_reg <= out_x;
            oy_reg <= out_y;
        end
        if (ctrl.mul1)
        begin
            crop_top_reg <= crop_top_next;
            sx_reg       <= sx_next;
            geom_bad_reg <= geom_bad_next;
        end
        if (ctrl.mul2)
        begin
            row_reg <= row_next;
        end
        if (ctrl.mul3)
        begin
            addr_reg <= addr_next;
        end
    end

    assign addr     = addr_reg;
    assign geom_bad = geom_bad_reg;

endmodule

// ----- src/crop_nearest_scale_normalize.sv -----
// ----------------------------------------------------------------------------
// crop_nearest_scale_normalize
// Luma plane store with nearest-neighbour crop and scale to a square output
// grid, each pixel returned as a 16-bit normalised value per channel.
// ----------------------------------------------------------------------------
// A load beat writes one byte into the plane store; loads at or beyond the
// store size are dropped. A request beat names one output pixel and occupies
// the block through the accepting cycle, three address stages (crop offset
// and column with two multipliers, cropped row with one, then row times
// stride plus column with one) and the registered read of the plane store,
// followed by OUT_CHANNELS result beats at one per cycle while the output
// side takes them. New input beats are taken only once the last result beat
// of a request has gone. Every request yields OUT_CHANNELS beats: invalid
// geometry (width 0, height 0 or 1, stride 0) reports status 1 and an address
// at or beyond the store reports status 2, both with a zero value. Configuration
// may be written only while the block is idle. Reading a store byte that was
// never loaded returns an undefined value.
// ----------------------------------------------------------------------------
module crop_nearest_scale_normalize #(
    parameter int OUT_CHANNELS = cnsn_pkg::OUT_CHANNELS_DEF,
    parameter int STORE_BYTES  = cnsn_pkg::STORE_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_write,
    input  logic [cnsn_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cnsn_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  cnsn_pkg::in_t                      in_data,

    output logic                               out_valid,
    input  logic                               out_ready,
    output cnsn_pkg::out_t                     out_data
);

    localparam int STORE_AW = $clog2(STORE_BYTES);
    localparam logic [cnsn_pkg::ADDR_CALC_W-1:0] STORE_LIMIT =
        cnsn_pkg::ADDR_CALC_W'(STORE_BYTES);
    localparam logic [cnsn_pkg::CHAN_W-1:0] LAST_CHAN = cnsn_pkg::CHAN_W'(OUT_CHANNELS - 1);

    // Configuration registers.
    cnsn_pkg::geom_t geom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.src_width     <= cnsn_pkg::SRC_WIDTH_RST;
            geom_reg.src_height    <= cnsn_pkg::SRC_HEIGHT_RST;
            geom_reg.row_stride    <= cnsn_pkg::ROW_STRIDE_RST;
            geom_reg.crop_top_frac <= cnsn_pkg::CROP_TOP_FRAC_RST;
        end
        else if (cfg_write)
        begin
            case (cnsn_pkg::cfg_index_t'(cfg_index))
                cnsn_pkg::REG_SRC_WIDTH:
                    geom_reg.src_width <= cfg_data[cnsn_pkg::DIM_W-1:0];
                cnsn_pkg::REG_SRC_HEIGHT:
                    geom_reg.src_height <= cfg_data[cnsn_pkg::DIM_W-1:0];
                cnsn_pkg::REG_ROW_STRIDE:
                    geom_reg.row_stride <= cfg_data[cnsn_pkg::STRIDE_W-1:0];
                cnsn_pkg::REG_CROP_TOP_FRAC:
                    geom_reg.crop_top_frac <= cfg_data;
                default:
                    geom_reg <= geom_reg;
            endcase
        end
    end

    // Sequencer state and per-request registers.
    cnsn_pkg::state_t            state_reg;
    cnsn_pkg::state_t            state_next;
    logic [cnsn_pkg::CHAN_W-1:0] chan_reg;
    logic [cnsn_pkg::CHAN_W-1:0] chan_next;
    cnsn_pkg::status_t           status_reg;
    cnsn_pkg::status_t           status_next;

    logic                             in_beat;
    logic                             out_beat;
    logic                             last_beat;
    logic                             load_in_range;
    logic                             ram_wr_en;
    logic                             ram_rd_en;
    logic [cnsn_pkg::BYTE_W-1:0]      ram_rd_data;
    logic [cnsn_pkg::ADDR_CALC_W-1:0] load_addr_ext;
    logic [cnsn_pkg::ADDR_CALC_W-1:0] src_addr;
    logic                             geom_bad;
    cnsn_pkg::dp_ctrl_t               dp_ctrl;

    assign in_beat   = in_valid && in_ready;
    assign out_beat  = out_valid && out_ready;
    assign last_beat = out_beat && (chan_reg == LAST_CHAN);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cnsn_pkg::S_IDLE:
            begin
                if (in_beat && (in_data.action == cnsn_pkg::ACT_REQUEST))
                begin
                    state_next = cnsn_pkg::S_MUL1;
                end
            end
            cnsn_pkg::S_MUL1: state_next = cnsn_pkg::S_MUL2;
            cnsn_pkg::S_MUL2: state_next = cnsn_pkg::S_MUL3;
            cnsn_pkg::S_MUL3: state_next = cnsn_pkg::S_READ;
            cnsn_pkg::S_READ: state_next = cnsn_pkg::S_EMIT;
            cnsn_pkg::S_EMIT:
            begin
                if (last_beat)
                begin
                    state_next = cnsn_pkg::S_IDLE;
                end
            end
            default: state_next = cnsn_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        ram_rd_en       = 1'b0;
        dp_ctrl         = '0;
        case (state_reg)
            cnsn_pkg::S_IDLE:
            begin
                in_ready        = 1'b1;
                dp_ctrl.capture = in_valid && (in_data.action == cnsn_pkg::ACT_REQUEST);
            end
            cnsn_pkg::S_MUL1: dp_ctrl.mul1 = 1'b1;
            cnsn_pkg::S_MUL2: dp_ctrl.mul2 = 1'b1;
            cnsn_pkg::S_MUL3: dp_ctrl.mul3 = 1'b1;
            cnsn_pkg::S_READ: ram_rd_en    = 1'b1;
            cnsn_pkg::S_EMIT: out_valid    = 1'b1;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // The status is settled while the store read is under way, so the data
    // and its status arrive together in the first result beat.
    always_comb
    begin
        status_next = status_reg;
        if (state_reg == cnsn_pkg::S_READ)
        begin
            if (geom_bad)
            begin
                status_next = cnsn_pkg::STS_GEOMETRY;
            end
            else if (src_addr >= STORE_LIMIT)
            begin
                status_next = cnsn_pkg::STS_RANGE;
            end
            else
            begin
                status_next = cnsn_pkg::STS_OK;
            end
        end
    end

    always_comb
    begin
        chan_next = chan_reg;
        if (last_beat)
        begin
            chan_next = '0;
        end
        else if (out_beat)
        begin
            chan_next = chan_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cnsn_pkg::S_IDLE;
            chan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    // Loads write straight into the store in the cycle they are accepted.
    assign load_addr_ext = cnsn_pkg::ADDR_CALC_W'(in_data.load_address);
    assign load_in_range = load_addr_ext < STORE_LIMIT;
    assign ram_wr_en     = in_beat && (in_data.action == cnsn_pkg::ACT_LOAD) && load_in_range;

    cnsn_addr_gen u_addr_gen (
        .clk      (clk),
        .ctrl     (dp_ctrl),
        .geom     (geom_reg),
        .out_x    (in_data.out_x),
        .out_y    (in_data.out_y),
        .addr     (src_addr),
        .geom_bad (geom_bad)
    );

    cnsn_ram #(
        .WIDTH (cnsn_pkg::BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_plane_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (load_addr_ext[STORE_AW-1:0]),
        .wr_data (in_data.load_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (src_addr[STORE_AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // Byte times 257 is the byte repeated in both halves of the word. The
    // read data register holds still for the whole burst of result beats.
    assign out_data.value_norm   = (status_reg == cnsn_pkg::STS_OK)
                                   ? {ram_rd_data, ram_rd_data} : '0;
    assign out_data.channel      = chan_reg;
    assign out_data.last_channel = (chan_reg == LAST_CHAN);
    assign out_data.status       = status_reg;

    // Input and output sides are never open in the same cycle.
    a_exclusive_sides: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input accepted while results pending");

    // A request shows its first result beat after the address and read stages.
    a_request_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (in_data.action == cnsn_pkg::ACT_REQUEST)) |=> ##4 out_valid)
        else $error("request result not presented on time");

    // After the last beat of a request the block is ready again.
    a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && out_data.last_channel) |=> in_ready)
        else $error("block not ready after last result beat");

    // Error beats carry a zero value.
    a_error_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.status != cnsn_pkg::STS_OK)) |-> (out_data.value_norm == '0))
        else $error("error beat carries a nonzero value");

    // Each burst opens on channel zero.
    a_burst_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (out_data.channel == '0))
        else $error("result burst does not start at channel zero");

endmodule
